// ----- sv/fasta_record_parser_top_assert.svh -----
// Assertion macros shared by the parser modules. Each expects signals named
// clk and rst in the module that uses it.
`ifndef FASTA_RECORD_PARSER_TOP_ASSERT_SVH
`define FASTA_RECORD_PARSER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FPR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define FPR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define FPR_ASSERT_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/fpr_pkg.sv -----
package fpr_pkg;

  localparam int OUT_W          = 32;
  localparam int NUM_TABLE_REGS = 8;
  localparam int TABLE_SEL_W    = 3;
  localparam int TABLE_REG_W    = 64;
  localparam int CFG_INDEX_W    = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_E     = 8'h65;

  typedef enum logic [1:0] {
    CLS_STRIP  = 2'd0,
    CLS_KEEP   = 2'd1,
    CLS_FATAL  = 2'd2,
    CLS_SILENT = 2'd3
  } class_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_RESIDUE = 2'd1,
    KIND_REC_END = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_HEADER = 2'd1,
    ERR_SIZE_ZERO  = 2'd2,
    ERR_FATAL_CHAR = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    M_START  = 3'd0,
    M_HEADER = 3'd1,
    M_SEQ    = 3'd2,
    M_ERROR  = 3'd3,
    M_DONE   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    PH_FIELD  = 3'd0,
    PH_KEY_I  = 3'd1,
    PH_KEY_Z  = 3'd2,
    PH_KEY_E  = 3'd3,
    PH_KEY_EQ = 3'd4,
    PH_EQUAL  = 3'd5,
    PH_DIGITS = 3'd6,
    PH_SKIP   = 3'd7
  } phase_t;

  // One classified input word as it waits in the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    class_t     cls;
    logic       is_gt;
    logic       is_nl;
    logic       is_semi;
    logic       is_digit;
  } word_t;

  // Character expected at each step of the "size=" keyword.
  function automatic logic [7:0] kw_char(input phase_t ph);
    logic [7:0] c;
    case (ph)
      PH_FIELD:  c = CH_S;
      PH_KEY_I:  c = CH_I;
      PH_KEY_Z:  c = CH_Z;
      PH_KEY_E:  c = CH_E;
      PH_KEY_EQ: c = CH_EQ;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic phase_t kw_next(input phase_t ph);
    phase_t n;
    case (ph)
      PH_FIELD:  n = PH_KEY_I;
      PH_KEY_I:  n = PH_KEY_Z;
      PH_KEY_Z:  n = PH_KEY_E;
      PH_KEY_E:  n = PH_KEY_EQ;
      PH_KEY_EQ: n = PH_EQUAL;
      default:   n = PH_SKIP;
    endcase
    return n;
  endfunction

endpackage

// ----- sv/fasta_record_parser_top.sv -----
// FASTA record parser. Input words carry one file byte (in_byte) or an
// end-of-stream mark (end_of_stream) on a valid/stall channel. Output words
// are header bytes, kept sequence residues, one record-end word per record
// (size annotation, header and sequence lengths, record number) and at most
// one error word, after which the parser goes quiet until reset.
// The eight class table registers are to be written through cfg_write,
// cfg_index and cfg_data while the parser is idle; the block itself does not
// enforce this. Writes to an index above seven are dropped. An accepted input
// word is written into the queue; when the back end pops it, any result word
// is registered in the output word register and out_valid rises with it.
// Throughput: one input word per cycle while in_stall is low; the back end
// pops a word whenever the output is not held, also one with no result.
// A four-word queue separates classification from parsing, so out_stall
// holds the output word and fills the queue; in_stall rises only when the
// queue is full. Reset is synchronous: it empties the queue, clears the
// class table to all-stripped and returns the parser to start of file.
module fasta_record_parser_top #(
  parameter int COUNT_WIDTH = 32,
  parameter int SIZE_WIDTH  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fpr_pkg::TABLE_REG_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte,
  input  logic                             end_of_stream,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       item_kind,
  output logic [7:0]                       data_byte,
  output logic [fpr_pkg::OUT_W-1:0]        size_value,
  output logic [fpr_pkg::OUT_W-1:0]        header_length,
  output logic [fpr_pkg::OUT_W-1:0]        sequence_length,
  output logic [fpr_pkg::OUT_W-1:0]        record_number,
  output logic [1:0]                       error_code,
  output logic [fpr_pkg::OUT_W-1:0]        line_number
);

  fpr_pkg::word_t front_word;
  fpr_pkg::word_t q_word;
  logic           q_full;
  logic           q_not_empty;
  logic           q_pop;
  logic           q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  fpr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .word          (front_word)
  );

  fpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (front_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (q_word),
    .not_empty (q_not_empty)
  );

  fpr_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SIZE_WIDTH  (SIZE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_not_empty     (q_not_empty),
    .q_word          (q_word),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .item_kind       (item_kind),
    .data_byte       (data_byte),
    .size_value      (size_value),
    .header_length   (header_length),
    .sequence_length (sequence_length),
    .record_number   (record_number),
    .error_code      (error_code),
    .line_number     (line_number)
  );

endmodule

// ----- sv/fpr_front.sv -----
module fpr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fpr_pkg::TABLE_REG_W-1:0]  cfg_data,
  input  logic [7:0]                       in_byte,
  input  logic                             end_of_stream,
  output fpr_pkg::word_t                   word
);

  logic [fpr_pkg::TABLE_REG_W-1:0] class_table [fpr_pkg::NUM_TABLE_REGS];
  logic [fpr_pkg::TABLE_REG_W-1:0] row;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fpr_pkg::NUM_TABLE_REGS; i++) begin
        class_table[i] <= '0;
      end
    end else if (cfg_write &&
                 cfg_index < fpr_pkg::CFG_INDEX_W'(fpr_pkg::NUM_TABLE_REGS)) begin
      class_table[cfg_index[fpr_pkg::TABLE_SEL_W-1:0]] <= cfg_data;
    end
  end

  // The upper three bits pick the register, the lower five the 2-bit slot.
  assign row = class_table[in_byte[7:5]];

  always_comb begin
    word.data     = in_byte;
    word.eos      = end_of_stream;
    word.cls      = fpr_pkg::class_t'(row[{in_byte[4:0], 1'b0} +: 2]);
    word.is_gt    = (in_byte == fpr_pkg::CH_GT);
    word.is_nl    = (in_byte == fpr_pkg::CH_NL);
    word.is_semi  = (in_byte == fpr_pkg::CH_SEMI);
    word.is_digit = (in_byte >= fpr_pkg::CH_ZERO) && (in_byte <= fpr_pkg::CH_NINE);
  end

endmodule

// ----- sv/fpr_queue.sv -----
`include "fasta_record_parser_top_assert.svh"

module fpr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fpr_pkg::word_t push_word,
  output logic           full,
  input  logic           pop,
  output fpr_pkg::word_t pop_word,
  output logic           not_empty
);

  fpr_pkg::word_t                  slots [fpr_pkg::QUEUE_DEPTH];
  logic [fpr_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [fpr_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [fpr_pkg::QUEUE_CNT_W-1:0] count;

  assign full      = (count == fpr_pkg::QUEUE_CNT_W'(fpr_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FPR_ASSERT_ALWAYS(a_count_bound, count <= fpr_pkg::QUEUE_CNT_W'(fpr_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `FPR_ASSERT_IMPLY(a_pop_nonempty, pop, count != '0, "pop from an empty queue")

endmodule

// ----- sv/fpr_back.sv -----
`include "fasta_record_parser_top_assert.svh"

module fpr_back #(
  parameter int COUNT_WIDTH = 32,
  parameter int SIZE_WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_not_empty,
  input  fpr_pkg::word_t               q_word,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   item_kind,
  output logic [7:0]                   data_byte,
  output logic [fpr_pkg::OUT_W-1:0]    size_value,
  output logic [fpr_pkg::OUT_W-1:0]    header_length,
  output logic [fpr_pkg::OUT_W-1:0]    sequence_length,
  output logic [fpr_pkg::OUT_W-1:0]    record_number,
  output logic [1:0]                   error_code,
  output logic [fpr_pkg::OUT_W-1:0]    line_number
);

  localparam logic [SIZE_WIDTH+3:0] SIZE_MAX_WIDE = {4'b0, {SIZE_WIDTH{1'b1}}};

  fpr_pkg::mode_t  mode, mode_next;
  fpr_pkg::phase_t ann_phase, ann_phase_next;

  logic                   at_line_start, at_line_start_next;
  logic [COUNT_WIDTH-1:0] header_count, header_count_next;
  logic [COUNT_WIDTH-1:0] residue_count, residue_count_next;
  logic [COUNT_WIDTH-1:0] record_count, record_count_next;
  logic [COUNT_WIDTH-1:0] line_count, line_count_next;
  logic [SIZE_WIDTH-1:0]  digit_acc, digit_acc_next;
  logic                   ann_found, ann_found_next;
  logic [SIZE_WIDTH-1:0]  ann_value, ann_value_next;

  logic                   found_fin;
  logic [SIZE_WIDTH-1:0]  value_fin;
  logic                   hdr_end;
  logic                   size_zero;
  logic                   seq_new;
  logic [SIZE_WIDTH+3:0]  acc_wide;

  logic                   emit;
  fpr_pkg::kind_t         e_kind;
  logic [7:0]             e_byte;
  logic [SIZE_WIDTH-1:0]  e_size;
  logic                   e_counts;
  fpr_pkg::err_t          e_err;

  assign pop = q_not_empty && (!out_valid || !out_stall);

  // The header closes with whatever digits are pending counted as a field.
  assign found_fin = ann_found || (ann_phase == fpr_pkg::PH_DIGITS);
  assign value_fin = ann_found ? ann_value :
                     ((ann_phase == fpr_pkg::PH_DIGITS) ? digit_acc : ann_value);
  assign hdr_end   = q_word.eos || q_word.is_nl;
  assign size_zero = found_fin && (value_fin == '0);
  assign seq_new   = at_line_start && q_word.is_gt;

  // acc * 10 + digit; anything above the size range saturates.
  assign acc_wide = ({4'b0, digit_acc} << 3) + ({4'b0, digit_acc} << 1) +
                    {{SIZE_WIDTH{1'b0}}, q_word.data[3:0]};

  always_comb begin
    mode_next = mode;
    if (pop) begin
      case (mode)
        fpr_pkg::M_START: begin
          if (q_word.eos) begin
            mode_next = fpr_pkg::M_DONE;
          end else if (q_word.is_gt) begin
            mode_next = fpr_pkg::M_HEADER;
          end else begin
            mode_next = fpr_pkg::M_ERROR;
          end
        end
        fpr_pkg::M_HEADER: begin
          if (hdr_end) begin
            if (size_zero) begin
              mode_next = fpr_pkg::M_ERROR;
            end else if (q_word.eos) begin
              mode_next = fpr_pkg::M_DONE;
            end else begin
              mode_next = fpr_pkg::M_SEQ;
            end
          end
        end
        fpr_pkg::M_SEQ: begin
          if (q_word.eos) begin
            mode_next = fpr_pkg::M_DONE;
          end else if (seq_new) begin
            mode_next = fpr_pkg::M_HEADER;
          end else if (q_word.cls == fpr_pkg::CLS_FATAL) begin
            mode_next = fpr_pkg::M_ERROR;
          end
        end
        default: mode_next = mode;
      endcase
    end
  end

  always_comb begin
    at_line_start_next = at_line_start;
    header_count_next  = header_count;
    residue_count_next = residue_count;
    record_count_next  = record_count;
    line_count_next    = line_count;
    ann_phase_next     = ann_phase;
    digit_acc_next     = digit_acc;
    ann_found_next     = ann_found;
    ann_value_next     = ann_value;
    emit     = 1'b0;
    e_kind   = fpr_pkg::KIND_HEADER;
    e_byte   = '0;
    e_size   = '0;
    e_counts = 1'b0;
    e_err    = fpr_pkg::ERR_NONE;
    if (pop) begin
      case (mode)
        fpr_pkg::M_START: begin
          if (!q_word.eos) begin
            if (q_word.is_gt) begin
              header_count_next  = '0;
              residue_count_next = '0;
              ann_phase_next     = fpr_pkg::PH_FIELD;
              digit_acc_next     = '0;
              ann_found_next     = 1'b0;
              ann_value_next     = SIZE_WIDTH'(1);
            end else begin
              emit   = 1'b1;
              e_kind = fpr_pkg::KIND_ERROR;
              e_byte = q_word.data;
              e_err  = fpr_pkg::ERR_BAD_HEADER;
            end
          end
        end
        fpr_pkg::M_HEADER: begin
          if (hdr_end) begin
            ann_found_next = found_fin;
            ann_value_next = value_fin;
            if (size_zero) begin
              emit   = 1'b1;
              e_kind = fpr_pkg::KIND_ERROR;
              e_err  = fpr_pkg::ERR_SIZE_ZERO;
            end else if (q_word.eos) begin
              emit     = 1'b1;
              e_kind   = fpr_pkg::KIND_REC_END;
              e_size   = found_fin ? value_fin : SIZE_WIDTH'(1);
              e_counts = 1'b1;
              record_count_next = (record_count == '1) ? record_count
                                                       : record_count + 1'b1;
            end else begin
              at_line_start_next = 1'b1;
              line_count_next = (line_count == '1) ? line_count : line_count + 1'b1;
            end
          end else begin
            emit   = 1'b1;
            e_kind = fpr_pkg::KIND_HEADER;
            e_byte = q_word.data;
            header_count_next = (header_count == '1) ? header_count
                                                     : header_count + 1'b1;
            if (!ann_found) begin
              if (q_word.is_semi) begin
                if (ann_phase == fpr_pkg::PH_DIGITS) begin
                  ann_found_next = 1'b1;
                  ann_value_next = digit_acc;
                end
                ann_phase_next = fpr_pkg::PH_FIELD;
              end else begin
                case (ann_phase)
                  fpr_pkg::PH_FIELD, fpr_pkg::PH_KEY_I, fpr_pkg::PH_KEY_Z,
                  fpr_pkg::PH_KEY_E, fpr_pkg::PH_KEY_EQ: begin
                    if (q_word.data == fpr_pkg::kw_char(ann_phase)) begin
                      ann_phase_next = fpr_pkg::kw_next(ann_phase);
                      if (ann_phase == fpr_pkg::PH_KEY_EQ) begin
                        digit_acc_next = '0;
                      end
                    end else begin
                      ann_phase_next = fpr_pkg::PH_SKIP;
                    end
                  end
                  fpr_pkg::PH_EQUAL, fpr_pkg::PH_DIGITS: begin
                    if (q_word.is_digit) begin
                      digit_acc_next = (acc_wide > SIZE_MAX_WIDE) ? '1
                                                                  : acc_wide[SIZE_WIDTH-1:0];
                      ann_phase_next = fpr_pkg::PH_DIGITS;
                    end else begin
                      ann_phase_next = fpr_pkg::PH_SKIP;
                    end
                  end
                  default: ann_phase_next = ann_phase;
                endcase
              end
            end
          end
        end
        fpr_pkg::M_SEQ: begin
          if (q_word.eos || seq_new) begin
            emit     = 1'b1;
            e_kind   = fpr_pkg::KIND_REC_END;
            e_size   = ann_found ? ann_value : SIZE_WIDTH'(1);
            e_counts = 1'b1;
            record_count_next = (record_count == '1) ? record_count
                                                     : record_count + 1'b1;
            if (seq_new && !q_word.eos) begin
              header_count_next  = '0;
              residue_count_next = '0;
              ann_phase_next     = fpr_pkg::PH_FIELD;
              digit_acc_next     = '0;
              ann_found_next     = 1'b0;
              ann_value_next     = SIZE_WIDTH'(1);
            end
          end else if (q_word.cls == fpr_pkg::CLS_FATAL) begin
            emit   = 1'b1;
            e_kind = fpr_pkg::KIND_ERROR;
            e_byte = q_word.data;
            e_err  = fpr_pkg::ERR_FATAL_CHAR;
          end else begin
            if (q_word.cls == fpr_pkg::CLS_KEEP) begin
              emit   = 1'b1;
              e_kind = fpr_pkg::KIND_RESIDUE;
              e_byte = q_word.data;
              residue_count_next = (residue_count == '1) ? residue_count
                                                         : residue_count + 1'b1;
            end
            if (q_word.is_nl) begin
              at_line_start_next = 1'b1;
              line_count_next = (line_count == '1) ? line_count : line_count + 1'b1;
            end else begin
              at_line_start_next = 1'b0;
            end
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= fpr_pkg::M_START;
      ann_phase     <= fpr_pkg::PH_FIELD;
      at_line_start <= 1'b1;
      header_count  <= '0;
      residue_count <= '0;
      record_count  <= '0;
      line_count    <= COUNT_WIDTH'(1);
      digit_acc     <= '0;
      ann_found     <= 1'b0;
      ann_value     <= SIZE_WIDTH'(1);
      out_valid     <= 1'b0;
    end else begin
      mode          <= mode_next;
      ann_phase     <= ann_phase_next;
      at_line_start <= at_line_start_next;
      header_count  <= header_count_next;
      residue_count <= residue_count_next;
      record_count  <= record_count_next;
      line_count    <= line_count_next;
      digit_acc     <= digit_acc_next;
      ann_found     <= ann_found_next;
      ann_value     <= ann_value_next;
      out_valid     <= emit || (out_valid && out_stall);
    end
  end

  // Output word register; lengths and record number only in record ends.
  always_ff @(posedge clk) begin
    if (emit) begin
      item_kind       <= e_kind;
      data_byte       <= e_byte;
      size_value      <= fpr_pkg::OUT_W'(e_size);
      header_length   <= e_counts ? fpr_pkg::OUT_W'(header_count) : '0;
      sequence_length <= e_counts ? fpr_pkg::OUT_W'(residue_count) : '0;
      record_number   <= e_counts ? fpr_pkg::OUT_W'(record_count) : '0;
      error_code      <= e_err;
      line_number     <= fpr_pkg::OUT_W'(line_count);
    end
  end

  `FPR_ASSERT_IMPLY_NEXT(a_error_sticky, mode == fpr_pkg::M_ERROR, mode == fpr_pkg::M_ERROR, "error mode left before reset")
  `FPR_ASSERT_IMPLY_NEXT(a_error_stops, emit && e_kind == fpr_pkg::KIND_ERROR, mode == fpr_pkg::M_ERROR, "error word without entering error mode")
  `FPR_ASSERT_IMPLY(a_emit_room, emit, !out_valid || !out_stall, "word emitted over a held output")

endmodule
